// ===== sv/ipv4_receive_header_check_defines.svh =====
// Assertion macros shared by the IPv4 receive header check RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH

// Same-cycle implication, checks off while reset is asserted
`define IRHC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checks off while reset is asserted
`define IRHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/irhc_pkg.sv =====
// Package for the IPv4 receive header check: verdict codes, register
// indexes, header constants and field widths. Depends on nothing.
`default_nettype none

package irhc_pkg;

    // Default width of each verdict counter
    localparam int COUNT_WIDTH_DEFAULT = 32;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int MAC_W      = 48;
    localparam int HLEN_W     = 6;
    localparam int PLEN_W     = 16;
    localparam int VCOUNT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 136;
    localparam int NUM_VERDICTS = 8;

    // Frame layout and header constants
    localparam logic [POS_W-1:0] ETH_LEN       = 16'd14;
    localparam logic [POS_W-1:0] MAC_SRC_FIRST = 16'd6;
    localparam logic [POS_W-1:0] MAC_SRC_END   = 16'd12;
    localparam logic [POS_W-1:0] MIN_HDR       = 16'd20;
    localparam logic [POS_W-1:0] POS_MAX       = 16'hffff;
    localparam logic [15:0]      FLAG_MORE     = 16'h2000;
    localparam logic [15:0]      OFFSET_MASK   = 16'h1fff;
    localparam logic [15:0]      SUM_GOOD      = 16'hffff;
    localparam logic [3:0]       IP_VERSION    = 4'd4;
    localparam logic [7:0]       PROTO_ICMP    = 8'd1;
    localparam logic [7:0]       PROTO_TCP     = 8'd6;
    localparam logic [7:0]       PROTO_UDP     = 8'd17;
    localparam logic [ADDR_W-1:0] ADDR_BCAST   = 32'hffff_ffff;

    // Header byte offsets, counted from the version/IHL byte
    localparam logic [POS_W-1:0] HOFS_VERSION  = 16'd0;
    localparam logic [POS_W-1:0] HOFS_TOTLEN_H = 16'd2;
    localparam logic [POS_W-1:0] HOFS_TOTLEN_L = 16'd3;
    localparam logic [POS_W-1:0] HOFS_FRAG_H   = 16'd6;
    localparam logic [POS_W-1:0] HOFS_FRAG_L   = 16'd7;
    localparam logic [POS_W-1:0] HOFS_PROTO    = 16'd9;
    localparam logic [POS_W-1:0] HOFS_SRC      = 16'd12;
    localparam logic [POS_W-1:0] HOFS_DST      = 16'd16;
    localparam logic [POS_W-1:0] HOFS_DST_END  = 16'd20;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_ADDRESS = 2'd0,
        CFG_ADDRESS_VALID = 2'd1
    } cfg_index_t;

    // Verdict codes
    typedef enum logic [2:0] {
        VERDICT_ICMP          = 3'd0,
        VERDICT_UDP           = 3'd1,
        VERDICT_TCP           = 3'd2,
        VERDICT_BAD_HEADER    = 3'd3,
        VERDICT_CHECKSUM      = 3'd4,
        VERDICT_FRAGMENT      = 3'd5,
        VERDICT_NOT_OURS      = 3'd6,
        VERDICT_UNKNOWN_PROTO = 3'd7
    } verdict_t;

endpackage

`default_nettype wire

// ===== sv/ipv4_receive_header_check.sv =====
// IPv4 receive header check: byte-stream header capture, checksum and verdict.
// Depends on irhc_pkg and ipv4_receive_header_check_defines.svh.
`default_nettype none
`include "ipv4_receive_header_check_defines.svh"

// Takes an Ethernet frame one byte per cycle on the s_ stream (tlast on the
// final byte) and returns one verdict transaction per frame on the m_ stream.
// Each byte is handled as it is accepted: the frame capture registers and the
// running ones'-complement sum update on each accepted byte, and the final
// byte copies the finished frame state into a check register, which the
// verdict logic and the eight verdict counters turn into the result register.
// A byte can be accepted every cycle while m_tready is high; the check
// register hands its frame to the result register once no earlier result is
// held there. Input stalls only while a judged frame waits in the check
// register behind a held result. The local address is written through the
// cfg_ channel (index 0 address, index 1 valid flag) and should only change
// while no frame is in flight. Reset clears the counters and the frame capture
// state at once; there is no clearing pass.
module ipv4_receive_header_check #(
    parameter int COUNT_WIDTH = irhc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [irhc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [irhc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Frame byte stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [irhc_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] frame_byte
    input  wire logic                              s_tlast,   // frame_end
    // Verdict stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] sender_address, [79:32] sender_mac, [80] learn_sender,
    // [86:81] header_length, [102:87] payload_length,
    // [134:103] verdict_count, [135] zero
    output logic [irhc_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [2:0]                             m_tuser    // [2:0] verdict
);

    localparam int PW = irhc_pkg::POS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [irhc_pkg::ADDR_W-1:0] local_addr_reg;
    logic                        addr_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg <= '0;
            addr_valid_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == irhc_pkg::CFG_LOCAL_ADDRESS) begin
                local_addr_reg <= cfg_data;
            end else if (cfg_index == irhc_pkg::CFG_ADDRESS_VALID) begin
                addr_valid_reg <= cfg_data[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic chk_valid_reg;
    logic out_free;
    logic chk_go;
    logic in_go;

    assign out_free = !m_tvalid || m_tready;
    assign chk_go   = chk_valid_reg && out_free;
    assign s_tready = !chk_valid_reg || out_free;
    assign in_go    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Frame capture: next state for the accepted byte
    // ------------------------------------------------------------------
    logic [PW-1:0]  pos_reg, pos_next;
    logic [15:0]    sum_reg, sum_next;
    logic [7:0]     pend_reg, pend_next;
    logic [7:0]     ver_reg, ver_next;
    logic [15:0]    tot_reg, tot_next;
    logic [15:0]    frag_reg, frag_next;
    logic [7:0]     proto_reg, proto_next;
    logic [31:0]    src_reg, src_next;
    logic [31:0]    tgt_reg, tgt_next;
    logic [47:0]    mac_reg, mac_next;

    logic [7:0]     in_byte;
    logic [PW-1:0]  hofs;
    logic           in_ip;
    logic [5:0]     ihl_cur;
    logic [16:0]    acc;

    assign in_byte = s_tdata;

    always_comb begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        ver_next   = ver_reg;
        tot_next   = tot_reg;
        frag_next  = frag_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        tgt_next   = tgt_reg;
        mac_next   = mac_reg;
        hofs       = pos_reg - irhc_pkg::ETH_LEN;
        in_ip      = (pos_reg >= irhc_pkg::ETH_LEN);
        acc        = {1'b0, sum_reg} + {1'b0, pend_reg, in_byte};

        // Source MAC bytes
        if (pos_reg >= irhc_pkg::MAC_SRC_FIRST && pos_reg < irhc_pkg::MAC_SRC_END) begin
            mac_next = {mac_reg[39:0], in_byte};
        end

        // Header field capture
        if (in_ip) begin
            if (hofs == irhc_pkg::HOFS_VERSION) begin
                ver_next = in_byte;
            end else if (hofs == irhc_pkg::HOFS_TOTLEN_H ||
                         hofs == irhc_pkg::HOFS_TOTLEN_L) begin
                tot_next = {tot_reg[7:0], in_byte};
            end else if (hofs == irhc_pkg::HOFS_FRAG_H ||
                         hofs == irhc_pkg::HOFS_FRAG_L) begin
                frag_next = {frag_reg[7:0], in_byte};
            end else if (hofs == irhc_pkg::HOFS_PROTO) begin
                proto_next = in_byte;
            end else if (hofs >= irhc_pkg::HOFS_SRC && hofs < irhc_pkg::HOFS_DST) begin
                src_next = {src_reg[23:0], in_byte};
            end else if (hofs >= irhc_pkg::HOFS_DST && hofs < irhc_pkg::HOFS_DST_END) begin
                tgt_next = {tgt_reg[23:0], in_byte};
            end
        end

        // Ones'-complement sum over the first IHL*4 header bytes
        ihl_cur = {ver_next[3:0], 2'b00};
        if (in_ip && hofs < {{(PW-6){1'b0}}, ihl_cur}) begin
            if (!hofs[0]) begin
                pend_next = in_byte;
            end else begin
                sum_next = acc[15:0] + {15'd0, acc[16]};
            end
        end

        // Saturating byte position
        if (pos_reg != irhc_pkg::POS_MAX) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // Advance frame state; clear it after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_go && s_tlast)) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            pend_reg  <= '0;
            ver_reg   <= '0;
            tot_reg   <= '0;
            frag_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            tgt_reg   <= '0;
            mac_reg   <= '0;
        end else if (in_go) begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            pend_reg  <= pend_next;
            ver_reg   <= ver_next;
            tot_reg   <= tot_next;
            frag_reg  <= frag_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            tgt_reg   <= tgt_next;
            mac_reg   <= mac_next;
        end
    end

    // ------------------------------------------------------------------
    // Check register: finished frame state, held until judged
    // ------------------------------------------------------------------
    logic [PW-1:0]  chk_pos_reg;
    logic [15:0]    chk_sum_reg;
    logic [7:0]     chk_ver_reg;
    logic [15:0]    chk_tot_reg;
    logic [15:0]    chk_frag_reg;
    logic [7:0]     chk_proto_reg;
    logic [31:0]    chk_src_reg;
    logic [31:0]    chk_tgt_reg;
    logic [47:0]    chk_mac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else if (in_go && s_tlast) begin
            chk_valid_reg <= 1'b1;
        end else if (chk_go) begin
            chk_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_go && s_tlast) begin
            chk_pos_reg   <= pos_reg;
            chk_sum_reg   <= sum_next;
            chk_ver_reg   <= ver_next;
            chk_tot_reg   <= tot_next;
            chk_frag_reg  <= frag_next;
            chk_proto_reg <= proto_next;
            chk_src_reg   <= src_next;
            chk_tgt_reg   <= tgt_next;
            chk_mac_reg   <= mac_next;
        end
    end

    // ------------------------------------------------------------------
    // Verdict logic
    // ------------------------------------------------------------------
    irhc_pkg::verdict_t verdict;
    logic [16:0]    frame_len;
    logic [16:0]    ip_len;
    logic [16:0]    ihl17;
    logic [16:0]    tot17;
    logic [5:0]     ihl_chk;
    logic           bad_hdr;
    logic           mine;
    logic           bcast;
    logic           learn;
    logic [15:0]    payload;

    always_comb begin
        ihl_chk   = {chk_ver_reg[3:0], 2'b00};
        frame_len = {1'b0, chk_pos_reg} + 17'd1;
        ip_len    = frame_len - {1'b0, irhc_pkg::ETH_LEN};
        ihl17     = {11'd0, ihl_chk};
        tot17     = {1'b0, chk_tot_reg};
        mine      = addr_valid_reg && (chk_tgt_reg == local_addr_reg);
        bcast     = (chk_tgt_reg == irhc_pkg::ADDR_BCAST);
        learn     = 1'b0;
        payload   = '0;
        bad_hdr   = (frame_len < {1'b0, irhc_pkg::ETH_LEN + irhc_pkg::MIN_HDR}) ||
                    (chk_ver_reg[7:4] != irhc_pkg::IP_VERSION) ||
                    (ihl17 < {1'b0, irhc_pkg::MIN_HDR}) ||
                    (ihl17 > ip_len) || (tot17 < ihl17) || (tot17 > ip_len);

        // Checks in priority order
        if (bad_hdr) begin
            verdict = irhc_pkg::VERDICT_BAD_HEADER;
        end else if (chk_sum_reg != irhc_pkg::SUM_GOOD) begin
            verdict = irhc_pkg::VERDICT_CHECKSUM;
        end else if ((chk_frag_reg & (irhc_pkg::FLAG_MORE | irhc_pkg::OFFSET_MASK)) != '0) begin
            verdict = irhc_pkg::VERDICT_FRAGMENT;
        end else if (!mine && !bcast) begin
            verdict = irhc_pkg::VERDICT_NOT_OURS;
        end else begin
            learn   = mine;
            payload = chk_tot_reg - {10'd0, ihl_chk};
            if (chk_proto_reg == irhc_pkg::PROTO_ICMP) begin
                verdict = irhc_pkg::VERDICT_ICMP;
            end else if (chk_proto_reg == irhc_pkg::PROTO_UDP) begin
                verdict = irhc_pkg::VERDICT_UDP;
            end else if (chk_proto_reg == irhc_pkg::PROTO_TCP) begin
                verdict = irhc_pkg::VERDICT_TCP;
            end else begin
                verdict = irhc_pkg::VERDICT_UNKNOWN_PROTO;
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict counters
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0]    cnt_reg [irhc_pkg::NUM_VERDICTS];
    logic [COUNT_WIDTH-1:0]    cnt_next;
    logic [COUNT_WIDTH+31:0]   cnt_ext;

    assign cnt_next = cnt_reg[verdict] + 1'b1;
    assign cnt_ext  = {32'd0, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < irhc_pkg::NUM_VERDICTS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (chk_go) begin
            cnt_reg[verdict] <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (chk_go) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (chk_go) begin
            m_tuser <= verdict;
            m_tdata <= {1'b0, cnt_ext[irhc_pkg::VCOUNT_W-1:0], payload, ihl_chk,
                        learn, chk_mac_reg, chk_src_reg};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IRHC_ASSERT_NEXT(a_judged_frame_shows, aclk, aresetn,
        chk_go, m_tvalid, "judged frame did not reach the result register")

    `IRHC_ASSERT_NOW(a_learn_only_on_delivery, aclk, aresetn,
        m_tvalid && m_tdata[80],
        m_tuser == irhc_pkg::VERDICT_ICMP || m_tuser == irhc_pkg::VERDICT_UDP ||
        m_tuser == irhc_pkg::VERDICT_TCP || m_tuser == irhc_pkg::VERDICT_UNKNOWN_PROTO,
        "learn flag set on a dropped frame")

    `IRHC_ASSERT_NOW(a_payload_only_on_delivery, aclk, aresetn,
        m_tvalid && m_tdata[102:87] != 16'd0,
        m_tuser == irhc_pkg::VERDICT_ICMP || m_tuser == irhc_pkg::VERDICT_UDP ||
        m_tuser == irhc_pkg::VERDICT_TCP || m_tuser == irhc_pkg::VERDICT_UNKNOWN_PROTO,
        "payload length reported on a dropped frame")

    `IRHC_ASSERT_NEXT(a_frame_state_cleared, aclk, aresetn,
        in_go && s_tlast, pos_reg == '0 && sum_reg == '0 && chk_valid_reg,
        "frame state not cleared after final byte")

endmodule

`default_nettype wire

// ===== bench/ipv4_receive_header_check_tb.sv =====
// Self-checking bench for ipv4_receive_header_check: drives Ethernet frames byte by byte
// and predicts every verdict transaction with its own copy of the header logic.
// Depends on irhc_pkg and the ipv4_receive_header_check RTL.
`default_nettype none

module ipv4_receive_header_check_tb;
    import irhc_pkg::*;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_IDLE      = 18;
    localparam int PHASE_BYTES   = 50;
    localparam int PHASE_FRAMES  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [15:0] FLAG_DONT_FRAG   = 16'h4000;
    localparam logic [7:0]  ETHERTYPE_HI     = 8'h08;
    localparam logic [7:0]  ETHERTYPE_LO     = 8'h00;
    localparam logic [7:0]  PROTO_UNASSIGNED = 8'hff;
    localparam logic [7:0]  IPV4_BASIC       = {IP_VERSION, 4'd5};
    localparam logic [7:0]  IPV4_SHORT_IHL   = {IP_VERSION, 4'd4};
    localparam logic [7:0]  IPV4_MAX_IHL     = {IP_VERSION, 4'd15};
    localparam logic [7:0]  IPV6_BASIC       = {4'd6, 4'd5};
    localparam int HOFS_CSUM_H = 10;
    localparam int HOFS_CSUM_L = 11;

    // One predicted verdict transaction
    typedef struct {
        verdict_t    verdict;
        bit [31:0]   sender_address;
        bit [47:0]   sender_mac;
        bit          learn_sender;
        bit [5:0]    header_length;
        bit [15:0]   payload_length;
        bit [31:0]   verdict_count;
    } verdict_rec_t;

    // Header tracker and verdict checker
    class verdict_board;
        bit [31:0]    own_address;
        bit           own_valid;
        int unsigned  position;
        int unsigned  ones_sum;
        bit [7:0]     high_byte;
        bit [7:0]     ver_ihl;
        bit [15:0]    total_len;
        bit [15:0]    frag_word;
        bit [7:0]     proto;
        bit [31:0]    src_ip;
        bit [31:0]    dst_ip;
        bit [47:0]    src_mac;
        bit [31:0]    verdict_tally [NUM_VERDICTS];
        verdict_rec_t expected_verdicts [$];
        int           errors;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == CFG_LOCAL_ADDRESS) own_address = value;
            else if (idx == CFG_ADDRESS_VALID) own_valid = value[0];
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void clear_frame();
            position  = 0;
            ones_sum  = 0;
            high_byte = 0;
            ver_ihl   = 0;
            total_len = 0;
            frag_word = 0;
            proto     = 0;
            src_ip    = 0;
            dst_ip    = 0;
            src_mac   = 0;
        endfunction

        // Capture one accepted byte; on the final byte queue the verdict
        function void take_frame_byte(bit [7:0] b, bit last);
            int unsigned  pos;
            int unsigned  hofs;
            int unsigned  ihl;
            int unsigned  len;
            int unsigned  acc;
            verdict_t     v;
            bit           mine;
            bit [15:0]    payload;
            verdict_rec_t rec;
            pos = position;
            if (pos >= MAC_SRC_FIRST && pos < MAC_SRC_END) src_mac = {src_mac[39:0], b};
            if (pos >= ETH_LEN) begin
                hofs = pos - ETH_LEN;
                if (hofs == HOFS_VERSION) ver_ihl = b;
                else if (hofs == HOFS_TOTLEN_H || hofs == HOFS_TOTLEN_L)
                    total_len = {total_len[7:0], b};
                else if (hofs == HOFS_FRAG_H || hofs == HOFS_FRAG_L)
                    frag_word = {frag_word[7:0], b};
                else if (hofs == HOFS_PROTO) proto = b;
                else if (hofs >= HOFS_SRC && hofs < HOFS_DST) src_ip = {src_ip[23:0], b};
                else if (hofs >= HOFS_DST && hofs < HOFS_DST_END) dst_ip = {dst_ip[23:0], b};
                // ones' complement sum with end-around carry over the header only
                ihl = 4 * ver_ihl[3:0];
                if (hofs < ihl) begin
                    if (hofs[0] == 1'b0) begin
                        high_byte = b;
                    end else begin
                        acc = ones_sum + {high_byte, b};
                        ones_sum = acc[15:0] + acc[16];
                    end
                end
            end
            if (position != POS_MAX) position++;
            if (!last) return;

            len     = pos + 1;
            ihl     = 4 * ver_ihl[3:0];
            mine    = 1'b0;
            payload = 0;
            if (len < ETH_LEN + MIN_HDR || ver_ihl[7:4] != IP_VERSION || ihl < MIN_HDR ||
                ihl > len - ETH_LEN || total_len < ihl || total_len > len - ETH_LEN) begin
                v = VERDICT_BAD_HEADER;
            end else if (ones_sum[15:0] != SUM_GOOD) begin
                v = VERDICT_CHECKSUM;
            end else if ((frag_word & FLAG_MORE) != 0 || (frag_word & OFFSET_MASK) != 0) begin
                v = VERDICT_FRAGMENT;
            end else begin
                mine = own_valid && dst_ip == own_address;
                if (!mine && dst_ip != ADDR_BCAST) begin
                    v = VERDICT_NOT_OURS;
                end else begin
                    payload = 16'(total_len - ihl);
                    case (proto)
                        PROTO_ICMP: v = VERDICT_ICMP;
                        PROTO_UDP:  v = VERDICT_UDP;
                        PROTO_TCP:  v = VERDICT_TCP;
                        default:    v = VERDICT_UNKNOWN_PROTO;
                    endcase
                end
            end
            verdict_tally[v]++;
            rec.verdict        = v;
            rec.sender_address = src_ip;
            rec.sender_mac     = src_mac;
            rec.learn_sender   = mine;
            rec.header_length  = ihl[5:0];
            rec.payload_length = payload;
            rec.verdict_count  = verdict_tally[v];
            expected_verdicts.push_back(rec);
            clear_frame();
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        // Match one verdict transaction against the oldest prediction
        function void check_verdict(logic [OUT_DATA_W-1:0] data, logic [2:0] user);
            verdict_rec_t e;
            if (expected_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected verdict, expected none, actual %0h / %0h",
                         $time, user, data);
                return;
            end
            e = expected_verdicts.pop_front();
            compare("verdict", e.verdict, user);
            compare("sender_address", e.sender_address, data[31:0]);
            compare("sender_mac", e.sender_mac, data[79:32]);
            compare("learn_sender", e.learn_sender, data[80]);
            compare("header_length", e.header_length, data[86:81]);
            compare("payload_length", e.payload_length, data[102:87]);
            compare("verdict_count", e.verdict_count, data[134:103]);
            compare("reserved bit", 1'b0, data[135]);
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [BYTE_W-1:0]       s_tdata   = '0;   // [7:0] frame_byte
    logic                    s_tlast   = 1'b0; // frame_end
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // [31:0] sender_address, [79:32] sender_mac, [80] learn_sender, [86:81] header_length,
    // [102:87] payload_length, [134:103] verdict_count, [135] zero
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [2:0]              m_tuser;          // [2:0] verdict

    verdict_board board = new();
    bit [7:0]     frame_q [$];
    int unsigned  bytes_sent = 0;
    int unsigned  cycle_count = 0;
    int           stall_left = 0;
    bit           rx_idle_on = 1'b1;
    bit           tail_quiet = 1'b0;

    ipv4_receive_header_check #(
        .COUNT_WIDTH(COUNT_WIDTH_DEFAULT)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #CLK_LOW aclk = 1'b1;
        #CLK_HIGH aclk = 1'b0;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Accept verdict transactions, stalling in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_verdict(m_tdata, m_tuser);
            if ($urandom_range(0, 255) == 0) rx_idle_on = !rx_idle_on;
            if (stall_left == 0 && rx_idle_on && !tail_quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, MAX_IDLE);
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one byte, optionally after an idle burst, and hold it until accepted
    task automatic send_byte(input bit [7:0] b, input bit last, input bit may_idle);
        int gap;
        gap = 0;
        if (may_idle && !tail_quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, MAX_IDLE);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        board.take_frame_byte(b, last);
    endtask

    task automatic send_frame(input bit may_idle);
        bit idle_frame;
        idle_frame = may_idle && ($urandom_range(0, 2) != 0);
        foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, idle_frame);
    endtask

    // Build an Ethernet frame around an IPv4 header with a computed checksum
    function automatic void compose_frame(bit [7:0] ver_ihl, bit [15:0] frag, bit [7:0] proto,
                                          bit [31:0] dst_ip, int body_len, int pad_len,
                                          bit good_sum);
        bit [7:0]    hdr [60];
        int          hlen;
        bit [15:0]   total;
        int unsigned fold;
        bit [15:0]   csum;
        bit          bcast_mac;
        hlen = 4 * ver_ihl[3:0];
        if (hlen < MIN_HDR) hlen = MIN_HDR;
        total = 16'(hlen + body_len);
        foreach (hdr[i]) hdr[i] = 8'($urandom);
        hdr[HOFS_VERSION]  = ver_ihl;
        hdr[HOFS_TOTLEN_H] = total[15:8];
        hdr[HOFS_TOTLEN_L] = total[7:0];
        hdr[HOFS_FRAG_H]   = frag[15:8];
        hdr[HOFS_FRAG_L]   = frag[7:0];
        hdr[HOFS_PROTO]    = proto;
        hdr[HOFS_CSUM_H]   = 8'h00;
        hdr[HOFS_CSUM_L]   = 8'h00;
        for (int i = 0; i < 4; i++) hdr[HOFS_DST + i] = dst_ip[31 - 8*i -: 8];
        fold = 0;
        for (int i = 0; i < hlen; i += 2) begin
            fold = fold + {hdr[i], hdr[i+1]};
            fold = (fold & 16'hffff) + (fold >> 16);
        end
        csum = ~fold[15:0];
        if (!good_sum) csum ^= 16'(1 << $urandom_range(0, 15));
        hdr[HOFS_CSUM_H] = csum[15:8];
        hdr[HOFS_CSUM_L] = csum[7:0];

        frame_q.delete();
        bcast_mac = ($urandom_range(0, 3) == 0);
        repeat (6) frame_q.push_back(bcast_mac ? 8'hff : 8'($urandom));
        repeat (6) frame_q.push_back(8'($urandom));
        frame_q.push_back(ETHERTYPE_HI);
        frame_q.push_back(ETHERTYPE_LO);
        for (int i = 0; i < hlen; i++) frame_q.push_back(hdr[i]);
        repeat (body_len + pad_len) frame_q.push_back(8'($urandom));
    endfunction

    task automatic send_header_frame(input bit [7:0] ver_ihl, input bit [15:0] frag,
                                     input bit [7:0] proto, input bit [31:0] dst_ip,
                                     input int body_len, input bit good_sum);
        compose_frame(ver_ihl, frag, proto, dst_ip, body_len, 0, good_sum);
        send_frame(1);
    endtask

    // Hold off until every verdict is back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_register(idx, value);
    endtask

    // Write the address pair, junk in the upper bits of the flag, optionally spare indexes
    task automatic set_config(input bit [31:0] addr, input bit valid, input bit spare);
        write_register(CFG_LOCAL_ADDRESS, addr);
        write_register(CFG_ADDRESS_VALID, ($urandom() & ~32'd1) | valid);
        if (spare) begin
            write_register(CFG_SPARE_2, $urandom());
            write_register(CFG_SPARE_3, $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, some broken, some pure noise
    task automatic random_frame();
        int          kind;
        int          r;
        int          cut;
        int          idx;
        bit [3:0]    ihl_n;
        bit [15:0]   frag;
        bit [7:0]    proto;
        bit [31:0]   dst;
        kind = $urandom_range(0, 99);
        if (kind >= 88) begin
            frame_q.delete();
            repeat ($urandom_range(1, 48)) frame_q.push_back(8'($urandom));
            send_frame(1);
            return;
        end
        ihl_n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        case ($urandom_range(0, 9))
            0, 1:    frag = FLAG_DONT_FRAG;
            7:       frag = FLAG_MORE | 16'($urandom_range(0, 3));
            8:       frag = 16'($urandom_range(1, OFFSET_MASK));
            9:       frag = 16'($urandom);
            default: frag = 16'h0000;
        endcase
        case ($urandom_range(0, 3))
            0:       proto = PROTO_ICMP;
            1:       proto = PROTO_UDP;
            2:       proto = PROTO_TCP;
            default: proto = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       dst = board.own_address;
            1:       dst = ADDR_BCAST;
            2:       dst = $urandom;
            default: dst = board.own_address ^ (32'd1 << $urandom_range(0, 31));
        endcase
        compose_frame({IP_VERSION, ihl_n}, frag, proto, dst, $urandom_range(0, 24),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0,
                      $urandom_range(0, 9) != 0);
        if (kind >= 70) begin
            case ($urandom_range(0, 4))
                0: begin
                    cut = $urandom_range(1, frame_q.size() - 1);
                    while (frame_q.size() > cut) void'(frame_q.pop_back());
                end
                1: begin
                    do r = $urandom_range(0, 15); while (r == IP_VERSION);
                    frame_q[ETH_LEN + HOFS_VERSION] = {r[3:0], frame_q[ETH_LEN + HOFS_VERSION][3:0]};
                end
                2: frame_q[ETH_LEN + HOFS_VERSION] = {IP_VERSION, 4'($urandom_range(0, 4))};
                3: begin
                    frame_q[ETH_LEN + HOFS_TOTLEN_H] = 8'($urandom);
                    frame_q[ETH_LEN + HOFS_TOTLEN_L] = 8'($urandom);
                end
                default: begin
                    idx = $urandom_range(0, frame_q.size() - 1);
                    frame_q[idx] ^= 8'(1 << $urandom_range(0, 7));
                end
            endcase
        end
        send_frame(1);
    endtask

    task automatic random_phase(input bit [31:0] addr, input bit valid, input bit spare);
        int          frames;
        int unsigned first_byte;
        drain();
        set_config(addr, valid, spare);
        frames = 0;
        first_byte = bytes_sent;
        while (frames < PHASE_FRAMES || bytes_sent - first_byte < PHASE_BYTES) begin
            random_frame();
            frames++;
        end
    endtask

    initial begin
        bit [31:0] own;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: a lone byte, a broadcast, and a zero target that is not ours
        frame_q = '{8'hff};
        send_frame(1);
        send_header_frame(IPV4_BASIC, 16'h0000, PROTO_ICMP, ADDR_BCAST, 4, 1);
        send_header_frame(IPV4_BASIC, 16'h0000, PROTO_UDP, 32'h0000_0000, 4, 1);

        // Directed frames against a configured address
        drain();
        own = $urandom;
        set_config(own, 1'b1, 1'b0);
        send_header_frame(IPV4_BASIC, 16'h0000, PROTO_ICMP, own, 0, 1);
        send_header_frame(IPV4_MAX_IHL, 16'h0000, PROTO_UDP, own, 8, 1);
        send_header_frame(IPV4_BASIC, FLAG_DONT_FRAG, PROTO_TCP, own, 12, 1);
        send_header_frame(IPV4_BASIC, 16'h0000, PROTO_UNASSIGNED, own, 3, 1);
        send_header_frame(IPV4_BASIC, 16'h0000, PROTO_TCP, ~own, 3, 1);
        send_header_frame(IPV4_BASIC, 16'h0000, PROTO_UDP, own, 5, 0);
        send_header_frame(IPV4_BASIC, FLAG_MORE, PROTO_UDP, own, 5, 1);
        send_header_frame(IPV4_BASIC, OFFSET_MASK, PROTO_UDP, own, 5, 1);
        send_header_frame(IPV4_SHORT_IHL, 16'h0000, PROTO_ICMP, own, 2, 1);
        send_header_frame(IPV6_BASIC, 16'h0000, PROTO_ICMP, own, 2, 1);
        // total length beyond the frame, then below the header
        compose_frame(IPV4_BASIC, 16'h0000, PROTO_UDP, own, 6, 0, 1);
        frame_q[ETH_LEN + HOFS_TOTLEN_H] = 8'hff;
        frame_q[ETH_LEN + HOFS_TOTLEN_L] = 8'hff;
        send_frame(1);
        compose_frame(IPV4_BASIC, 16'h0000, PROTO_UDP, own, 6, 0, 1);
        frame_q[ETH_LEN + HOFS_TOTLEN_H] = 8'h00;
        frame_q[ETH_LEN + HOFS_TOTLEN_L] = 8'h00;
        send_frame(1);
        // frame ending inside the header, padded frame, all-ones frame
        compose_frame(IPV4_BASIC, 16'h0000, PROTO_TCP, own, 0, 0, 1);
        while (frame_q.size() > 25) void'(frame_q.pop_back());
        send_frame(1);
        compose_frame(IPV4_BASIC, 16'h0000, PROTO_ICMP, own, 10, 18, 1);
        send_frame(1);
        frame_q.delete();
        repeat (60) frame_q.push_back(8'hff);
        send_frame(1);

        // Random traffic across several address settings, extremes included
        random_phase($urandom, 1'b1, 1'b0);
        random_phase(ADDR_BCAST, 1'b1, 1'b0);
        random_phase(32'h0000_0000, 1'b1, 1'b1);
        random_phase($urandom, 1'b0, 1'b0);
        tail_quiet = 1'b1;
        random_phase($urandom, 1'b1, 1'b0);
        drain();

        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/irhc_pkg.sv
sv/ipv4_receive_header_check.sv
bench/ipv4_receive_header_check_tb.sv
